[rtl/soc_pkg.sv]
// ----------------------------------------------------------------------------
// soc_pkg
// Shared types and constants for the sphere obstacle clearance check unit.
// ----------------------------------------------------------------------------
`default_nettype none

package soc_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 32;
    localparam int DIST_W  = 34;
    localparam int SLOT_W  = 3;
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 1;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 8;

    // pipeline depth of the distance unit
    localparam int PIPE_LAT = 3;

    localparam logic [DIST_W-1:0] OBST_CLEAR_RST = 34'd131072;
    localparam logic [DIST_W-1:0] UAV_CLEAR_RST  = 34'd78643;

    localparam logic [IDX_W-1:0] CFG_OBST_CLEAR = 1'd0;
    localparam logic [IDX_W-1:0] CFG_UAV_CLEAR  = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_OBST = 2'd0,
        CMD_SET_VEH  = 2'd1,
        CMD_QUERY    = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        HIT_NONE = 2'd0,
        HIT_OBST = 2'd1,
        HIT_VEH  = 2'd2
    } hit_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic   valid;
        point_t pt;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/soc_cell.sv]
// ----------------------------------------------------------------------------
// soc_cell
// One table cell: holds an entry, takes its neighbor's entry on shift or a new
// entry on load.
// ----------------------------------------------------------------------------
`default_nettype none

module soc_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire soc_pkg::cell_ctrl_t ctrl,
    input  wire soc_pkg::entry_t     prev_in,
    input  wire soc_pkg::entry_t     load_in,
    output soc_pkg::entry_t          q
);
    import soc_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    point_t pt_reg;
    point_t pt_next;

    always_comb
    begin
        priority if (ctrl.load)
        begin
            valid_next = load_in.valid;
            pt_next    = load_in.pt;
        end
        else if (ctrl.shift)
        begin
            valid_next = prev_in.valid;
            pt_next    = prev_in.pt;
        end
        else
        begin
            valid_next = valid_reg;
            pt_next    = pt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_reg <= pt_next;
    end

    assign q = '{valid: valid_reg, pt: pt_reg};

endmodule

`default_nettype wire

[rtl/soc_dist.sv]
// ----------------------------------------------------------------------------
// soc_dist
// Three-stage squared distance and clearance compare between two points.
// ----------------------------------------------------------------------------
`default_nettype none

module soc_dist (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire soc_pkg::point_t            a,
    input  wire soc_pkg::point_t            b,
    input  wire logic [soc_pkg::DIST_W-1:0] thr,
    output logic                            hit
);
    import soc_pkg::*;

    logic                     en1_reg;
    logic                     en2_reg;
    logic                     hit_reg;
    logic                     hit_next;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [DIFF_W-1:0] dx_next, dy_next, dz_next;
    logic signed [2*DIFF_W-1:0] px, py, pz;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg, sqz_reg;
    logic [DIST_W-1:0]        sum;

    assign dx_next = {a.x[COORD_W-1], a.x} - {b.x[COORD_W-1], b.x};
    assign dy_next = {a.y[COORD_W-1], a.y} - {b.y[COORD_W-1], b.y};
    assign dz_next = {a.z[COORD_W-1], a.z} - {b.z[COORD_W-1], b.z};

    // |d| <= 65535 so the square fits in 32 bits
    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;
    assign pz = dz_reg * dz_reg;

    assign sum = DIST_W'(sqx_reg) + DIST_W'(sqy_reg) + DIST_W'(sqz_reg);
    assign hit_next = en2_reg && (sum < thr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en1_reg <= 1'b0;
            en2_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            en1_reg <= en;
            en2_reg <= en1_reg;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        dz_reg  <= dz_next;
        sqx_reg <= px[SQ_W-1:0];
        sqy_reg <= py[SQ_W-1:0];
        sqz_reg <= pz[SQ_W-1:0];
    end

    assign hit = hit_reg;

endmodule

`default_nettype wire

[rtl/sphere_obstacle_clearance_check_unit.sv]
// ----------------------------------------------------------------------------
// sphere_obstacle_clearance_check_unit
// Keeps obstacle centres and vehicle positions in rings of cells and checks
// query points for clearance against both.
// ----------------------------------------------------------------------------
// usage:
//   s_* carries commands: s_tuser the command (add obstacle, set vehicle slot,
//   query), s_tdata the slot and the x, y, z point. m_* returns one item per
//   command: point_free, hit_kind, status. cfg_* writes both squared clearance
//   thresholds; the user must do so only while the unit is idle (unchecked).
// timing:
//   add and set commands update the tables at acceptance (an add to a full
//   obstacle table is dropped and flagged in status) and give their result
//   item from the result state once the output register is free. a query
//   rotates both rings once, each past its own distance unit, one entry per
//   cycle, then drains the three-stage distance pipeline into the result
//   register. one command is in work at a time; s_tready is high whenever
//   no command is in work, even while a result item waits on m_tready.
// reset:
//   both tables empty, thresholds 2.0 and 1.2 in Q18.16, no item pending.
//   a stalled receiver holds the result item; a finished command waits for
//   the output register to free before the next one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_obstacle_clearance_check_unit #(
    parameter int MAX_OBSTACLES = 64,
    parameter int MAX_VEHICLES  = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // slot[2:0], x_pos[18:3], y_pos[34:19], z_pos[50:35], zero fill
    input  wire logic [soc_pkg::S_DATA_W-1:0] s_tdata,
    // command[1:0]
    input  wire logic [soc_pkg::CMD_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // point_free[0], hit_kind[2:1], status[3], zero fill
    output logic [soc_pkg::M_DATA_W-1:0]      m_tdata,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [soc_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [soc_pkg::DIST_W-1:0]   cfg_data
);
    import soc_pkg::*;

    localparam int SCAN_LEN = (MAX_OBSTACLES > MAX_VEHICLES) ? MAX_OBSTACLES : MAX_VEHICLES;
    localparam int SCAN_END = SCAN_LEN + PIPE_LAT;
    localparam int CNT_W    = $clog2(SCAN_END + 1);
    localparam int OCNT_W   = $clog2(MAX_OBSTACLES + 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [OCNT_W-1:0] obst_count_reg, obst_count_next;
    logic              obs_hit_reg, obs_hit_next;
    logic              veh_hit_reg, veh_hit_next;
    logic              drop_reg, drop_next;
    logic              m_valid_reg, m_valid_next;
    cmd_t              cmd_reg, cmd_next;
    point_t            query_reg, query_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [DIST_W-1:0] obst_clear_reg, uav_clear_reg;

    logic       in_fire;
    cmd_t       in_cmd;
    point_t     in_pt;
    logic [SLOT_W-1:0] in_slot;
    logic       obst_full;
    logic       add_fire;
    logic       set_fire;
    logic       obst_scan;
    logic       veh_scan;
    logic       obs_hit;
    logic       veh_hit;
    logic       out_free;
    hit_kind_t  kind;

    entry_t     obst_q [MAX_OBSTACLES];
    entry_t     veh_q  [MAX_VEHICLES];
    entry_t     obst_head;
    entry_t     new_entry;
    cell_ctrl_t obst_ctrl;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_slot  = s_tdata[SLOT_W-1:0];
    assign in_pt    = '{x: s_tdata[18:3], y: s_tdata[34:19], z: s_tdata[50:35]};
    assign in_fire  = s_tvalid && s_tready;
    assign obst_full = (obst_count_reg == OCNT_W'(MAX_OBSTACLES));
    assign add_fire = in_fire && (in_cmd == CMD_ADD_OBST) && !obst_full;
    assign set_fire = in_fire && (in_cmd == CMD_SET_VEH);
    assign new_entry = '{valid: 1'b1, pt: in_pt};

    assign obst_scan = (state_reg == ST_SCAN) && (scan_cnt_reg < CNT_W'(MAX_OBSTACLES));
    assign veh_scan  = (state_reg == ST_SCAN) && (scan_cnt_reg < CNT_W'(MAX_VEHICLES));

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_free  = !m_valid_reg || m_tready;

    // obstacle ring: adds shift in at the head, a query rotates it once
    assign obst_head = add_fire ? new_entry : obst_q[MAX_OBSTACLES-1];
    assign obst_ctrl = '{shift: add_fire || obst_scan, load: 1'b0};

    for (genvar i = 0; i < MAX_OBSTACLES; i++)
    begin : g_obst
        soc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (obst_ctrl),
            .prev_in ((i == 0) ? obst_head : obst_q[(i == 0) ? 0 : i - 1]),
            .load_in (new_entry),
            .q       (obst_q[i])
        );
    end

    // vehicle ring: slot writes load one cell, a query rotates it once
    for (genvar j = 0; j < MAX_VEHICLES; j++)
    begin : g_veh
        cell_ctrl_t veh_ctrl;

        assign veh_ctrl = '{shift: veh_scan, load: set_fire && (32'(in_slot) == j)};

        soc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (veh_ctrl),
            .prev_in ((j == 0) ? veh_q[MAX_VEHICLES-1] : veh_q[(j == 0) ? 0 : j - 1]),
            .load_in (new_entry),
            .q       (veh_q[j])
        );
    end

    soc_dist u_obst_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (obst_scan && obst_q[MAX_OBSTACLES-1].valid),
        .a     (obst_q[MAX_OBSTACLES-1].pt),
        .b     (query_reg),
        .thr   (obst_clear_reg),
        .hit   (obs_hit)
    );

    soc_dist u_veh_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (veh_scan && veh_q[MAX_VEHICLES-1].valid),
        .a     (veh_q[MAX_VEHICLES-1].pt),
        .b     (query_reg),
        .thr   (uav_clear_reg),
        .hit   (veh_hit)
    );

    always_comb
    begin
        priority if (obs_hit_reg)
            kind = HIT_OBST;
        else if (veh_hit_reg)
            kind = HIT_VEH;
        else
            kind = HIT_NONE;
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        obst_count_next = obst_count_reg;
        obs_hit_next    = obs_hit_reg | obs_hit;
        veh_hit_next    = veh_hit_reg | veh_hit;
        drop_next       = drop_reg;
        cmd_next        = cmd_reg;
        query_next      = query_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next      = in_cmd;
                    query_next    = in_pt;
                    obs_hit_next  = 1'b0;
                    veh_hit_next  = 1'b0;
                    scan_cnt_next = '0;
                    drop_next     = (in_cmd == CMD_ADD_OBST) && obst_full;
                    if (add_fire)
                        obst_count_next = obst_count_reg + OCNT_W'(1);
                    state_next = (in_cmd == CMD_QUERY) ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (scan_cnt_reg == CNT_W'(SCAN_END - 1))
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    if (cmd_reg == CMD_QUERY)
                    begin
                        m_data_next[0]   = (kind == HIT_NONE);
                        m_data_next[2:1] = kind;
                    end
                    m_data_next[3] = drop_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_cnt_reg   <= '0;
            obst_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            obst_count_reg <= obst_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obs_hit_reg <= obs_hit_next;
        veh_hit_reg <= veh_hit_next;
        drop_reg    <= drop_next;
        cmd_reg     <= cmd_next;
        query_reg   <= query_next;
        m_data_reg  <= m_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obst_clear_reg <= OBST_CLEAR_RST;
            uav_clear_reg  <= UAV_CLEAR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_OBST_CLEAR: obst_clear_reg <= cfg_data;
                CFG_UAV_CLEAR:  uav_clear_reg  <= cfg_data;
                default:        obst_clear_reg <= obst_clear_reg;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        obst_count_reg <= OCNT_W'(MAX_OBSTACLES))
        else $error("obstacle count beyond table size");

    a_full_add_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (in_cmd == CMD_ADD_OBST) && obst_full |=> $stable(obst_count_reg))
        else $error("add to full table changed count");

    a_free_means_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> (m_tdata[2:1] == HIT_NONE) && !m_tdata[3])
        else $error("free point reported with a hit or drop");

    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !s_tready)
        else $error("input taken during scan");

endmodule

`default_nettype wire
